// ===== hw/rtl/hdcp_pkg.sv =====
// Shared types and constants for the hex draw command parser.
// No dependencies; imported by every module of the block.
package hdcp_pkg;

	// Result kinds as delivered on the result channel
	typedef enum logic [3:0] {
		KIND_COLOR    = 4'd0,
		KIND_PIXEL    = 4'd1,
		KIND_LINE     = 4'd2,
		KIND_RECT     = 4'd3,
		KIND_FILL     = 4'd4,
		KIND_UPDATE   = 4'd5,
		KIND_QUIT     = 4'd6,
		KIND_BAD_OP   = 4'd7,
		KIND_BAD_BYTE = 4'd8,
		KIND_BAD_WORD = 4'd9
	} kind_t;

	// Decoded command handed from the parser to the formatter
	typedef struct packed {
		kind_t       kind;
		logic [15:0] word_a;
		logic [15:0] word_b;
		logic [15:0] word_c;
		logic [15:0] word_d;
	} cmd_item_t;

	// Default depth of the queue between parser and formatter
	localparam int FIFO_DEPTH_DEF = 4;

endpackage

// ===== hw/rtl/hex_draw_command_parser.sv =====
// Top level of the hex draw command parser: parser, command queue, formatter.
// Depends on hdcp_pkg, hdcp_front, hdcp_fifo and hdcp_back.
//
// Takes one character per cycle: a byte is accepted whenever the command
// queue has room, and each byte updates only the parser registers, so the
// sustained rate is one character per clock. A command result reaches the
// output register through the queue slot, written at the accepting edge,
// and the formatter register, loaded once the output side can take it. The
// queue of Depth entries lets the parser keep taking characters while the
// output side stalls. After a quit result the parser swallows every further
// byte until reset.
module hex_draw_command_parser #(
	parameter int Depth = hdcp_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  result_kind,
	output logic [15:0] param_a,
	output logic [15:0] param_b,
	output logic [15:0] param_c,
	output logic [15:0] param_d,
	output logic [23:0] color_rgb
);
	import hdcp_pkg::*;

	cmd_item_t push_item, pop_item;
	logic      push, pop, full, empty, halted;
	kind_t     kind;

	hdcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_byte (char_byte),
		.q_full    (full),
		.q_push    (push),
		.q_item    (push_item),
		.halted    (halted)
	);

	hdcp_fifo #(.Depth(Depth)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	hdcp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (empty),
		.q_item      (pop_item),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (kind),
		.param_a     (param_a),
		.param_b     (param_b),
		.param_c     (param_c),
		.param_d     (param_d),
		.color_rgb   (color_rgb)
	);

	assign result_kind = kind;

	// Nothing is queued once the parser has halted after quit
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halted) && halted |-> !push)
		else $error("push after halt");

	// A push is never offered into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	// Color only on color results
	a_rgb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind != KIND_COLOR) |-> color_rgb == 24'd0)
		else $error("color on non-color result");

	// Extra words zero on pixel, quit and bad-op results
	a_words_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_PIXEL || result_kind == KIND_QUIT ||
		result_kind == KIND_BAD_OP) |-> param_c == 16'd0 && param_d == 16'd0)
		else $error("unused words not cleared");

endmodule

// ===== hw/rtl/hdcp_front.sv =====
// Character parser: classifies bytes and assembles hex fields into commands.
// Depends on hdcp_pkg; pushes one decoded command per completing byte.
module hdcp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            char_byte,
	input  logic                  q_full,
	output logic                  q_push,
	output hdcp_pkg::cmd_item_t   q_item,
	output logic                  halted
);
	import hdcp_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_FIELDS, PH_HALTED} phase_t;
	typedef enum logic [2:0] {CMD_COLOR, CMD_PIXEL, CMD_LINE, CMD_RECT, CMD_FILL} cmd_t;

	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_L     = 8'h4c;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_Q     = 8'h51;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0a;

	phase_t      phase_q, phase_d;
	cmd_t        cmd_q, cmd_d;
	logic [1:0]  fnum_q, fnum_d;
	logic [2:0]  dleft_q, dleft_d;
	logic [15:0] acc_q, acc_d;
	logic        bad_q, bad_d;
	logic [15:0] store_q [4];

	logic        fire;
	logic        is_blank;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic        field_done;
	logic [15:0] field_val;
	logic [2:0]  dleft_dec;
	logic [2:0]  nfields;
	logic        last_field;
	logic        start;
	cmd_t        start_cmd;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;
	assign halted   = (phase_q == PH_HALTED);
	assign is_blank = (char_byte == CH_SPACE) || (char_byte == CH_NL);

	// Decode lowercase hex digit
	always_comb begin
		hex_ok  = 1'b0;
		hex_val = 4'd0;
		if (char_byte >= 8'h30 && char_byte <= 8'h39) begin
			hex_ok  = 1'b1;
			hex_val = 4'(char_byte - 8'h30);
		end else if (char_byte >= 8'h61 && char_byte <= 8'h66) begin
			hex_ok  = 1'b1;
			hex_val = 4'(char_byte - 8'h57);
		end
	end

	assign dleft_dec  = (dleft_q != 3'd0) ? dleft_q - 3'd1 : 3'd0;
	assign nfields    = (cmd_q == CMD_COLOR) ? 3'd3 : (cmd_q == CMD_PIXEL) ? 3'd2 : 3'd4;
	assign last_field = ({1'b0, fnum_q} + 3'd1) >= nfields;
	assign field_val  = hex_ok ? {acc_q[11:0], hex_val} : 16'd0;
	assign field_done = !hex_ok || (dleft_dec == 3'd0);

	// Next-state and push decode
	always_comb begin
		phase_d   = phase_q;
		cmd_d     = cmd_q;
		fnum_d    = fnum_q;
		dleft_d   = dleft_q;
		acc_d     = acc_q;
		bad_d     = bad_q;
		q_push    = 1'b0;
		start     = 1'b0;
		start_cmd = CMD_COLOR;
		q_item.kind   = KIND_BAD_OP;
		q_item.word_a = (fnum_q == 2'd0) ? field_val : store_q[0];
		q_item.word_b = (fnum_q == 2'd1) ? field_val : store_q[1];
		q_item.word_c = (fnum_q == 2'd2) ? field_val : store_q[2];
		q_item.word_d = (fnum_q == 2'd3) ? field_val : store_q[3];
		if (fire) begin
			unique case (phase_q)
				PH_IDLE: begin
					unique case (char_byte)
						CH_C: begin start = 1'b1; start_cmd = CMD_COLOR; end
						CH_P: begin start = 1'b1; start_cmd = CMD_PIXEL; end
						CH_L: begin start = 1'b1; start_cmd = CMD_LINE; end
						CH_R: begin start = 1'b1; start_cmd = CMD_RECT; end
						CH_F: begin start = 1'b1; start_cmd = CMD_FILL; end
						CH_SPACE, CH_NL: begin end
						CH_U: begin
							q_push      = 1'b1;
							q_item.kind = KIND_UPDATE;
						end
						CH_Q: begin
							q_push      = 1'b1;
							q_item.kind = KIND_QUIT;
							phase_d     = PH_HALTED;
						end
						default: begin
							q_push      = 1'b1;
							q_item.kind = KIND_BAD_OP;
						end
					endcase
				end
				PH_FIELDS: begin
					if (!is_blank) begin
						acc_d   = field_val;
						dleft_d = hex_ok ? dleft_dec : dleft_q;
						if (!hex_ok)
							bad_d = 1'b1;
						if (field_done) begin
							acc_d = 16'd0;
							if (last_field) begin
								q_push  = 1'b1;
								phase_d = PH_IDLE;
								fnum_d  = 2'd0;
								dleft_d = 3'd0;
								if (bad_d) begin
									q_item.kind = (cmd_q == CMD_COLOR) ? KIND_BAD_BYTE
									                                    : KIND_BAD_WORD;
								end else begin
									unique case (cmd_q)
										CMD_COLOR: q_item.kind = KIND_COLOR;
										CMD_PIXEL: q_item.kind = KIND_PIXEL;
										CMD_LINE:  q_item.kind = KIND_LINE;
										CMD_RECT:  q_item.kind = KIND_RECT;
										default:   q_item.kind = KIND_FILL;
									endcase
								end
							end else begin
								fnum_d  = fnum_q + 2'd1;
								dleft_d = (cmd_q == CMD_COLOR) ? 3'd2 : 3'd4;
							end
						end
					end
				end
				default: begin end
			endcase
		end
		// Open a new command
		if (start) begin
			cmd_d   = start_cmd;
			fnum_d  = 2'd0;
			dleft_d = (start_cmd == CMD_COLOR) ? 3'd2 : 3'd4;
			acc_d   = 16'd0;
			bad_d   = 1'b0;
			phase_d = PH_FIELDS;
		end
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= CMD_COLOR;
			fnum_q  <= 2'd0;
			dleft_q <= 3'd0;
			acc_q   <= 16'd0;
			bad_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			fnum_q  <= fnum_d;
			dleft_q <= dleft_d;
			acc_q   <= acc_d;
			bad_q   <= bad_d;
		end
	end

	// Store finished fields
	always_ff @(posedge clk) begin
		if (fire && phase_q == PH_FIELDS && !is_blank && field_done)
			store_q[fnum_q] <= field_val;
	end

endmodule

// ===== hw/rtl/hdcp_fifo.sv =====
// Short queue of decoded commands between parser and formatter.
// Depends on hdcp_pkg for the item type.
module hdcp_fifo #(
	parameter int Depth = hdcp_pkg::FIFO_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hdcp_pkg::cmd_item_t push_item,
	output logic                full,
	input  logic                pop,
	output hdcp_pkg::cmd_item_t pop_item,
	output logic                empty
);
	import hdcp_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_item_t         slot_q [Depth];
	logic [PtrW-1:0]   wptr_q, rptr_q;
	logic [CntW-1:0]   count_q;

	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);
	assign pop_item = slot_q[rptr_q];

	// Write slot
	always_ff @(posedge clk) begin
		if (push && !full)
			slot_q[wptr_q] <= push_item;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push && !full)
				wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
			if (pop && !empty)
				rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
			if ((push && !full) && !(pop && !empty))
				count_q <= count_q + 1'b1;
			else if (!(push && !full) && (pop && !empty))
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/hdcp_back.sv =====
// Result formatter: drains the command queue into the output register.
// Depends on hdcp_pkg; zeroes every field a result kind does not use.
module hdcp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  hdcp_pkg::cmd_item_t q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output hdcp_pkg::kind_t     result_kind,
	output logic [15:0]         param_a,
	output logic [15:0]         param_b,
	output logic [15:0]         param_c,
	output logic [15:0]         param_d,
	output logic [23:0]         color_rgb
);
	import hdcp_pkg::*;

	logic        valid_q;
	kind_t       kind_q;
	logic [15:0] pa_q, pb_q, pc_q, pd_q;
	logic [23:0] rgb_q;

	assign q_pop     = !q_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	// Format fields per result kind
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_item.kind;
			pa_q   <= 16'd0;
			pb_q   <= 16'd0;
			pc_q   <= 16'd0;
			pd_q   <= 16'd0;
			rgb_q  <= 24'd0;
			case (q_item.kind)
				KIND_COLOR: rgb_q <= {q_item.word_a[7:0], q_item.word_b[7:0],
				                      q_item.word_c[7:0]};
				KIND_PIXEL: begin
					pa_q <= q_item.word_a;
					pb_q <= q_item.word_b;
				end
				KIND_LINE, KIND_RECT, KIND_FILL: begin
					pa_q <= q_item.word_a;
					pb_q <= q_item.word_b;
					pc_q <= q_item.word_c;
					pd_q <= q_item.word_d;
				end
				default: begin end
			endcase
		end
	end

	assign result_kind = kind_q;
	assign param_a     = pa_q;
	assign param_b     = pb_q;
	assign param_c     = pc_q;
	assign param_d     = pd_q;
	assign color_rgb   = rgb_q;

endmodule

// ===== tb/hex_draw_command_parser_tb.sv =====
// Self-checking testbench for hex_draw_command_parser: character stream in,
// decoded draw commands out, both over valid/ready. Depends on hdcp_pkg and
// the RTL only; a scoreboard class predicts every result and checks it.
`timescale 1ns / 100ps

module hex_draw_command_parser_tb;
	import hdcp_pkg::*;

	localparam int ItemTarget = 1700;
	localparam int CalmTail   = 200;
	localparam int QuietLimit = 400;

	// Characters the command language gives meaning to
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_NINE    = "9";
	localparam logic [7:0] CH_LOWER_A = "a";
	localparam logic [7:0] CH_LOWER_F = "f";
	localparam logic [7:0] CH_UPPER_A = "A";
	localparam logic [7:0] CH_C       = "C";
	localparam logic [7:0] CH_P       = "P";
	localparam logic [7:0] CH_L       = "L";
	localparam logic [7:0] CH_R       = "R";
	localparam logic [7:0] CH_F       = "F";
	localparam logic [7:0] CH_U       = "U";
	localparam logic [7:0] CH_Q       = "Q";

	typedef struct {
		kind_t       kind;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
		logic [23:0] rgb;
	} draw_result_t;

	typedef enum logic [1:0] {AWAIT_LETTER, READ_FIELDS, HALTED} parse_phase_t;

	function automatic bit is_hex(logic [7:0] ch);
		return (ch >= CH_ZERO && ch <= CH_NINE) || (ch >= CH_LOWER_A && ch <= CH_LOWER_F);
	endfunction

	function automatic bit is_blank(logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_NEWLINE;
	endfunction

	// Predicts decoded commands from accepted characters and checks results
	class draw_scoreboard;
		parse_phase_t phase;
		kind_t        command;
		int           field_idx;
		int           digits_left;
		logic [15:0]  accum;
		logic [15:0]  words [4];
		bit           bad_seen;
		draw_result_t pending_draws [$];
		int           fail_count;

		function new();
			phase       = AWAIT_LETTER;
			command     = KIND_COLOR;
			field_idx   = 0;
			digits_left = 0;
			accum       = '0;
			bad_seen    = 1'b0;
			fail_count  = 0;
			foreach (words[i])
				words[i] = '0;
		endfunction

		function int pending();
			return pending_draws.size();
		endfunction

		function bit is_idle();
			return phase == AWAIT_LETTER;
		endfunction

		function void flag(string msg);
			fail_count++;
			if (fail_count <= 10)
				$display("MISMATCH: %s", msg);
		endfunction

		function int field_total();
			return (command == KIND_COLOR) ? 3 : (command == KIND_PIXEL) ? 2 : 4;
		endfunction

		function int field_digits();
			return (command == KIND_COLOR) ? 2 : 4;
		endfunction

		function void push_plain(kind_t k);
			draw_result_t r;
			r.kind = k;
			r.a    = '0;
			r.b    = '0;
			r.c    = '0;
			r.d    = '0;
			r.rgb  = '0;
			pending_draws.push_back(r);
		endfunction

		function void open_command(kind_t k);
			command     = k;
			field_idx   = 0;
			digits_left = field_digits();
			accum       = '0;
			bad_seen    = 1'b0;
			phase       = READ_FIELDS;
		endfunction

		// Build the result of a finished command from the stored words
		function void close_command();
			if (bad_seen) begin
				push_plain((command == KIND_COLOR) ? KIND_BAD_BYTE : KIND_BAD_WORD);
				return;
			end
			push_plain(command);
			if (command == KIND_COLOR) begin
				pending_draws[$].rgb = {words[0][7:0], words[1][7:0], words[2][7:0]};
			end else begin
				pending_draws[$].a = words[0];
				pending_draws[$].b = words[1];
				if (command != KIND_PIXEL) begin
					pending_draws[$].c = words[2];
					pending_draws[$].d = words[3];
				end
			end
		endfunction

		// Advance the parser by one accepted character
		function void decode_char(logic [7:0] ch);
			logic [3:0] nibble;
			bit         valid_digit;
			bit         done;
			nibble      = '0;
			valid_digit = 1'b1;
			done        = 1'b0;
			if (phase == HALTED)
				return;
			if (phase == AWAIT_LETTER) begin
				case (ch)
					CH_C: open_command(KIND_COLOR);
					CH_P: open_command(KIND_PIXEL);
					CH_L: open_command(KIND_LINE);
					CH_R: open_command(KIND_RECT);
					CH_F: open_command(KIND_FILL);
					CH_SPACE, CH_NEWLINE: ;
					CH_U: push_plain(KIND_UPDATE);
					CH_Q: begin
						push_plain(KIND_QUIT);
						phase = HALTED;
					end
					default: push_plain(KIND_BAD_OP);
				endcase
				return;
			end
			// skip blanks inside a field without counting them
			if (is_blank(ch))
				return;
			if (ch >= CH_ZERO && ch <= CH_NINE)
				nibble = 4'(ch - CH_ZERO);
			else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F)
				nibble = 4'(ch - CH_LOWER_A + 8'd10);
			else
				valid_digit = 1'b0;
			if (!valid_digit) begin
				bad_seen = 1'b1;
				accum    = '0;
				done     = 1'b1;
			end else begin
				accum = {accum[11:0], nibble};
				if (digits_left > 0)
					digits_left--;
				done = (digits_left == 0);
			end
			if (!done)
				return;
			words[field_idx] = accum;
			if (field_idx + 1 >= field_total()) begin
				close_command();
				phase       = AWAIT_LETTER;
				field_idx   = 0;
				digits_left = 0;
			end else begin
				field_idx++;
				digits_left = field_digits();
			end
			accum = '0;
		endfunction

		// Compare one delivered result with the oldest prediction
		function void check_result(draw_result_t got);
			draw_result_t want;
			if (pending_draws.size() == 0) begin
				flag($sformatf("result kind %0d with nothing expected", got.kind));
				return;
			end
			want = pending_draws.pop_front();
			if (got.kind !== want.kind || got.a !== want.a || got.b !== want.b ||
					got.c !== want.c || got.d !== want.d || got.rgb !== want.rgb) begin
				flag($sformatf({"expected kind %0d a %h b %h c %h d %h rgb %h, ",
					"got kind %0d a %h b %h c %h d %h rgb %h"},
					want.kind, want.a, want.b, want.c, want.d, want.rgb,
					got.kind, got.a, got.b, got.c, got.d, got.rgb));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  result_kind;
	logic [15:0] param_a;
	logic [15:0] param_b;
	logic [15:0] param_c;
	logic [15:0] param_d;
	logic [23:0] color_rgb;

	draw_scoreboard sb = new();

	bit send_idle  = 1'b1;
	bit recv_idle  = 1'b1;
	bit allow_quit = 1'b0;
	int item_count = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	hex_draw_command_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_byte   (char_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.param_a     (param_a),
		.param_b     (param_b),
		.param_c     (param_c),
		.param_d     (param_d),
		.color_rgb   (color_rgb)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stall the result side in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (recv_idle && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(1, 7) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		draw_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.kind = kind_t'(result_kind);
			got.a    = param_a;
			got.b    = param_b;
			got.c    = param_c;
			got.d    = param_d;
			got.rgb  = color_rgb;
			sb.check_result(got);
		end
	end

	// End the run when neither side moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic logic [7:0] hex_char(int unsigned v);
		return (v < 10) ? CH_ZERO + 8'(v) : CH_LOWER_A + 8'(v - 10);
	endfunction

	function automatic logic [7:0] blank_char();
		return $urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE;
	endfunction

	// Any byte that is neither a hex digit nor a blank, uppercase hex often
	function automatic logic [7:0] invalid_char();
		logic [7:0] ch;
		do begin
			if ($urandom_range(0, 2) == 0)
				ch = CH_UPPER_A + 8'($urandom_range(0, 5));
			else
				ch = 8'($urandom_range(0, 255));
		end while (is_hex(ch) || is_blank(ch));
		return ch;
	endfunction

	// Drive one character and hold it until the transaction completes
	task automatic send_char(input logic [7:0] ch);
		int gap;
		// keep the stream alive: a quit letter while idle would halt it
		if (ch == CH_Q && !allow_quit && sb.is_idle())
			ch = CH_U;
		gap = (send_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		char_byte <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.decode_char(ch);
		item_count++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Drop valid and hold off until every predicted result has arrived
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// One random command: mostly well formed, some corrupted, some noise
	task automatic send_command();
		int pick;
		int nfields;
		int ndigits;
		int bad_field;
		int bad_digit;
		int fill;
		logic [7:0] letter;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			repeat ($urandom_range(1, 3))
				send_char(8'($urandom_range(0, 255)));
		end else if (pick < 17) begin
			send_char(CH_U);
		end else if (pick < 20) begin
			send_char(blank_char());
		end else begin
			case ($urandom_range(0, 4))
				0: letter = CH_C;
				1: letter = CH_P;
				2: letter = CH_L;
				3: letter = CH_R;
				default: letter = CH_F;
			endcase
			nfields   = (letter == CH_C) ? 3 : (letter == CH_P) ? 2 : 4;
			ndigits   = (letter == CH_C) ? 2 : 4;
			bad_field = ($urandom_range(0, 5) == 0) ? $urandom_range(0, nfields - 1) : -1;
			bad_digit = $urandom_range(0, ndigits - 1);
			send_char(letter);
			for (int f = 0; f < nfields; f++) begin
				// bias some words to all zeros or all ones
				fill = $urandom_range(0, 5);
				for (int d = 0; d < ndigits; d++) begin
					if ($urandom_range(0, 9) == 0)
						send_char(blank_char());
					if (f == bad_field && d == bad_digit) begin
						send_char(invalid_char());
						break;
					end
					send_char(hex_char((fill == 0) ? 0 : (fill == 1) ? 15 :
						$urandom_range(0, 15)));
				end
			end
		end
		if ($urandom_range(0, 3) == 0)
			send_char(blank_char());
	endtask

	initial begin
		bit paused_mid;
		paused_mid = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: color with blank inside a field, update, bad op,
		// uppercase and other invalid digits for color and line
		send_text("Cff0\n0a5U z CAg00LxyzW\n ");
		wait_drained();

		// Random commands with idling modes changing along the way
		while (item_count < ItemTarget - CalmTail) begin
			if ($urandom_range(0, 24) == 0) begin
				send_idle = $urandom_range(0, 1);
				recv_idle = $urandom_range(0, 1);
			end
			if (!paused_mid && item_count >= ItemTarget / 2) begin
				wait_drained();
				paused_mid = 1'b1;
			end
			send_command();
		end

		// Full rate on both sides for the tail
		send_idle = 1'b0;
		recv_idle = 1'b0;
		while (item_count < ItemTarget)
			send_command();

		// Finish any open command, quit, then show the rest is ignored
		while (!sb.is_idle())
			send_char(CH_ZERO);
		allow_quit = 1'b1;
		send_char(CH_Q);
		repeat (8)
			send_char(8'($urandom_range(0, 255)));
		wait_drained();
		repeat (10) @(posedge clk);

		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
